// ===== sv/atsg_pkg.sv =====
package atsg_pkg;

    localparam int IDX_W    = 32;
    localparam int RATE_W   = 18;
    localparam int VAL_W    = 14;
    localparam int FREQ_W   = 11;
    localparam int PROD_W   = IDX_W + FREQ_W;
    localparam int BND_W    = 26;
    localparam int SCALED_W = 42;

    localparam int DIGIT_W    = 4;
    localparam int MOD_STAGES = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MOD_W      = MOD_STAGES * DIGIT_W;

    // input, boundary, frequency, product, modulo stages, output
    localparam int LATENCY = 5 + MOD_STAGES;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_KIND   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    localparam int MS_SEG1 = 60;
    localparam int MS_GAP  = 90;
    localparam int MS_LOW  = 120;
    localparam int MS_CRIT = 180;
    localparam int MS_PER_S = 1000;

    localparam logic [FREQ_W-1:0] FREQ_OFF  = FREQ_W'(0);
    localparam logic [FREQ_W-1:0] FREQ_1200 = FREQ_W'(1200);
    localparam logic [FREQ_W-1:0] FREQ_880  = FREQ_W'(880);
    localparam logic [FREQ_W-1:0] FREQ_660  = FREQ_W'(660);

    localparam logic signed [VAL_W-1:0] AMP_POS = VAL_W'(6000);
    localparam logic signed [VAL_W-1:0] AMP_NEG = -VAL_W'(6000);
    localparam logic signed [VAL_W-1:0] AMP_OFF = VAL_W'(0);

    typedef enum logic [1:0] {
        TONE_NONE     = 2'd0,
        TONE_LOW      = 2'd1,
        TONE_CRITICAL = 2'd2
    } tone_t;

    typedef struct packed {
        logic valid;
        logic silent;
    } ctl_t;

    // one restoring remainder step per dividend bit, most significant first
    function automatic logic [RATE_W-1:0] mod_digit(
        input logic [RATE_W-1:0]  rem,
        input logic [DIGIT_W-1:0] dig,
        input logic [RATE_W-1:0]  divisor
    );
        logic [RATE_W:0]   t;
        logic [RATE_W-1:0] r;
        r = rem;
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            t = {r, dig[i]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[RATE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/atsg_mod_pipe.sv =====
module atsg_mod_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atsg_pkg::ctl_t              in_ctl,
    input  logic [atsg_pkg::MOD_W-1:0]  dividend,
    input  logic [atsg_pkg::RATE_W-1:0] divisor,
    output atsg_pkg::ctl_t              out_ctl,
    output logic [atsg_pkg::RATE_W-1:0] remainder
);
    import atsg_pkg::*;

    ctl_t              ctl_reg [MOD_STAGES];
    logic [MOD_W-1:0]  dvd_reg [MOD_STAGES];
    logic [RATE_W-1:0] rem_reg [MOD_STAGES];

    ctl_t              ctl_next [MOD_STAGES];
    logic [MOD_W-1:0]  dvd_next [MOD_STAGES];
    logic [RATE_W-1:0] rem_next [MOD_STAGES];

    // each stage consumes the top digit of the remaining dividend
    always_comb
    begin
        for (int s = 0; s < MOD_STAGES; s++)
        begin
            if (s == 0)
            begin
                ctl_next[s] = in_ctl;
                rem_next[s] = mod_digit('0, dividend[MOD_W-1 -: DIGIT_W], divisor);
                dvd_next[s] = dividend << DIGIT_W;
            end
            else
            begin
                ctl_next[s] = ctl_reg[s-1];
                rem_next[s] = mod_digit(rem_reg[s-1], dvd_reg[s-1][MOD_W-1 -: DIGIT_W],
                                        divisor);
                dvd_next[s] = dvd_reg[s-1] << DIGIT_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MOD_STAGES; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < MOD_STAGES; s++)
            begin
                ctl_reg[s] <= ctl_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MOD_STAGES; s++)
        begin
            dvd_reg[s] <= dvd_next[s];
            rem_reg[s] <= rem_next[s];
        end
    end

    assign out_ctl   = ctl_reg[MOD_STAGES-1];
    assign remainder = rem_reg[MOD_STAGES-1];

endmodule

// ===== sv/alert_tone_square_wave_generator.sv =====
// Square-wave alert tone generator. One request (start, sample_index) is taken
// every clock cycle; busy never rises. The matching sample appears on
// sample_value with done high exactly 16 cycles after the request, in request
// order, and must be taken in that cycle. The latency is set by the phase
// modulo, a restoring remainder pipeline of 11 stages retiring four product
// bits each, behind four stages for boundary scaling, segment selection and
// the index-by-frequency multiply, and one output register. Configuration
// writes take effect at once and are to be made only with no request in flight.
module alert_tone_square_wave_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [atsg_pkg::IDX_W-1:0]           sample_index,
    output logic                                 done,
    output logic signed [atsg_pkg::VAL_W-1:0]    sample_value,
    input  logic                                 cfg_we,
    input  logic [atsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [atsg_pkg::RATE_W-1:0]          cfg_data
);
    import atsg_pkg::*;

    tone_t             tone_kind_reg;
    logic [RATE_W-1:0] sample_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_kind_reg   <= TONE_NONE;
            sample_rate_reg <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TONE_KIND:   tone_kind_reg   <= tone_t'(cfg_data[1:0]);
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: capture
    logic             v0_reg;
    logic [IDX_W-1:0] idx0_reg;

    // stage 1: scaled index and segment boundaries (ms * rate)
    logic                v1_reg;
    logic [IDX_W-1:0]    idx1_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [BND_W-1:0]    b60_reg, b90_reg, b120_reg, b180_reg;

    // stage 2: frequency choice
    logic              v2_reg;
    logic [IDX_W-1:0]  idx2_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [FREQ_W-1:0] freq_next;

    // stage 3: phase product
    ctl_t              ctl3_reg;
    logic [MOD_W-1:0]  prod_reg;

    ctl_t              mod_ctl;
    logic [RATE_W-1:0] phase;

    logic                     done_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic signed [VAL_W-1:0]  value_next;

    // idx >= floor(X / 1000)  <=>  idx * 1000 + 999 >= X
    logic ge60, ge90, ge120, ge180;
    assign ge60  = scaled_reg >= SCALED_W'(b60_reg);
    assign ge90  = scaled_reg >= SCALED_W'(b90_reg);
    assign ge120 = scaled_reg >= SCALED_W'(b120_reg);
    assign ge180 = scaled_reg >= SCALED_W'(b180_reg);

    always_comb
    begin
        freq_next = FREQ_OFF;
        unique case (tone_kind_reg)
            TONE_LOW:
            begin
                if (!ge120)
                begin
                    freq_next = ge60 ? FREQ_660 : FREQ_880;
                end
            end
            TONE_CRITICAL:
            begin
                priority if (ge180) freq_next = FREQ_OFF;
                else if (!ge60)     freq_next = FREQ_1200;
                else if (!ge90)     freq_next = FREQ_OFF;
                else                freq_next = FREQ_880;
            end
            default: freq_next = FREQ_OFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg          <= start && !busy;
            v1_reg          <= v0_reg;
            v2_reg          <= v1_reg;
            ctl3_reg.valid  <= v2_reg;
            ctl3_reg.silent <= (freq_reg == FREQ_OFF) || (sample_rate_reg == '0);
            done_reg        <= mod_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        idx0_reg   <= sample_index;
        idx1_reg   <= idx0_reg;
        scaled_reg <= SCALED_W'(idx0_reg) * SCALED_W'(MS_PER_S) + SCALED_W'(MS_PER_S - 1);
        b60_reg    <= BND_W'(sample_rate_reg) * BND_W'(MS_SEG1);
        b90_reg    <= BND_W'(sample_rate_reg) * BND_W'(MS_GAP);
        b120_reg   <= BND_W'(sample_rate_reg) * BND_W'(MS_LOW);
        b180_reg   <= BND_W'(sample_rate_reg) * BND_W'(MS_CRIT);
        idx2_reg   <= idx1_reg;
        freq_reg   <= freq_next;
        prod_reg   <= MOD_W'(PROD_W'(idx2_reg) * PROD_W'(freq_reg));
        value_reg  <= value_next;
    end

    atsg_mod_pipe u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (ctl3_reg),
        .dividend  (prod_reg),
        .divisor   (sample_rate_reg),
        .out_ctl   (mod_ctl),
        .remainder (phase)
    );

    always_comb
    begin
        if (mod_ctl.silent)
        begin
            value_next = AMP_OFF;
        end
        else if (phase < (sample_rate_reg >> 1))
        begin
            value_next = AMP_POS;
        end
        else
        begin
            value_next = AMP_NEG;
        end
    end

    assign done         = done_reg;
    assign sample_value = value_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sample_value == AMP_POS || sample_value == AMP_NEG
                  || sample_value == AMP_OFF))
        else $error("sample outside the three tone levels");

endmodule

// ===== sim/tb_alert_tone_square_wave_generator.sv =====
`timescale 1ns / 100ps

module tb_alert_tone_square_wave_generator;

    import atsg_pkg::*;

    localparam logic signed [VAL_W-1:0] TONE_HIGH = 14'sd6000;
    localparam logic signed [VAL_W-1:0] TONE_DOWN = -14'sd6000;
    localparam logic signed [VAL_W-1:0] SILENCE   = 14'sd0;
    localparam logic [1:0]              TONE_SPARE = 2'd3;   // unused selector value
    localparam int                      PHASES     = 24;
    localparam int                      PER_PHASE  = 75;
    localparam int                      QUIET_TAIL = 4;      // last phases run without gaps

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] value;
    } tone_sample_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [IDX_W-1:0]         sample_index = '0;
    logic                     done;
    logic signed [VAL_W-1:0]  sample_value;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_TONE_KIND;
    logic [RATE_W-1:0]        cfg_data = '0;

    logic [IDX_W-1:0]         index_q[$];
    tone_sample_t             sample_q[$];
    logic [1:0]               tone_cfg = TONE_NONE;
    logic [RATE_W-1:0]        rate_cfg = RATE_RESET;
    logic                     req_taken = 1'b0;
    bit                       gaps_on = 1'b1;
    int                       gap_left = 0;
    int                       n_sent = 0;
    int                       n_taken = 0;
    int                       n_checked = 0;
    int                       n_errors = 0;
    int                       n_high = 0;
    int                       n_down = 0;
    int                       n_quiet = 0;
    int                       n_settings = 0;

    alert_tone_square_wave_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .done         (done),
        .sample_value (sample_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // segment end in samples, truncated
    function automatic longint unsigned seg_end(input int unsigned ms, input longint unsigned rate);
        return (longint'(ms) * rate) / 64'(MS_PER_S);
    endfunction

    function automatic logic signed [VAL_W-1:0] square_sample(
        input logic [1:0]        kind,
        input logic [RATE_W-1:0] rate,
        input logic [IDX_W-1:0]  idx
    );
        longint unsigned r;
        longint unsigned i;
        longint unsigned phase;
        int unsigned     freq;
        r = 64'(rate);
        i = 64'(idx);
        freq = 0;
        if (r == 0)
        begin
            return SILENCE;
        end
        if (kind == TONE_LOW)
        begin
            if (i < seg_end(MS_SEG1, r))
                freq = 880;
            else if (i < seg_end(MS_LOW, r))
                freq = 660;
        end
        else if (kind == TONE_CRITICAL)
        begin
            // silent gap between 60 and 90 ms
            if (i < seg_end(MS_SEG1, r))
                freq = 1200;
            else if (i >= seg_end(MS_GAP, r) && i < seg_end(MS_CRIT, r))
                freq = 880;
        end
        if (freq == 0)
        begin
            return SILENCE;
        end
        phase = (i * 64'(freq)) % r;
        return (phase < r / 2) ? TONE_HIGH : TONE_DOWN;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [RATE_W-1:0] rate);
        longint           edge_at;
        int unsigned      sel;
        int unsigned      ms_pick[4];
        sel = $urandom_range(0, 99);
        ms_pick = '{MS_SEG1, MS_GAP, MS_LOW, MS_CRIT};
        if (sel < 70)
        begin
            return IDX_W'($urandom_range(0, 32'(seg_end(MS_CRIT, 64'(rate))) + 20));
        end
        else if (sel < 85)
        begin
            edge_at = longint'(seg_end(ms_pick[$urandom_range(0, 3)], 64'(rate)))
                      + longint'($urandom_range(0, 4)) - 2;
            return (edge_at < 0) ? '0 : IDX_W'(edge_at);
        end
        return IDX_W'($urandom());
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RATE_W'(1);
            2: return RATE_W'($urandom_range(2, 1000));
            3: return RATE_W'(8000);
            4: return RATE_W'(44100);
            5: return RATE_W'(48000);
            6: return RATE_W'(192000);
            7: return '1;
            default: return RATE_W'($urandom_range(1000, (1 << RATE_W) - 1));
        endcase
    endfunction

    function automatic logic [1:0] pick_tone();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return TONE_NONE;
        if (sel == 1)
            return TONE_SPARE;
        return (sel < 6) ? TONE_LOW : TONE_CRITICAL;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_TONE_KIND)
            tone_cfg = data[1:0];
        else
            rate_cfg = data;
    endtask

    task automatic configure(input logic [1:0] kind, input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] junk;
        junk = RATE_W'($urandom());
        // upper bits of the tone write are don't-care on the block side
        write_reg(REG_TONE_KIND, {junk[RATE_W-1:2], kind});
        write_reg(REG_SAMPLE_RATE, rate);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send(input logic [IDX_W-1:0] idx);
        index_q.push_back(idx);
        n_sent++;
    endtask

    // wait until every request has been taken and answered, then let the pipe empty
    task automatic settle();
        do
            @(negedge clk);
        while (n_taken != n_sent || sample_q.size() != 0);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || req_taken)
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (index_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                start <= 1'b0;
                gap_left = $urandom_range(0, 9);
            end
            else
            begin
                start        <= 1'b1;
                sample_index <= index_q.pop_front();
            end
        end
    end

    always @(posedge clk)
    begin
        tone_sample_t exp_s;
        req_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                exp_s.idx   = sample_index;
                exp_s.value = square_sample(tone_cfg, rate_cfg, sample_index);
                sample_q.push_back(exp_s);
                n_taken++;
            end
            if (done)
            begin
                if (sample_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, sample_value);
                    n_errors++;
                end
                else
                begin
                    exp_s = sample_q.pop_front();
                    if (sample_value !== exp_s.value)
                    begin
                        $display("%0t: sample_value for index %0d: expected %0d, got %0d",
                                 $time, exp_s.idx, exp_s.value, sample_value);
                        n_errors++;
                    end
                    n_checked++;
                    if (exp_s.value == TONE_HIGH)
                        n_high++;
                    else if (exp_s.value == TONE_DOWN)
                        n_down++;
                    else
                        n_quiet++;
                end
            end
        end
    end

    initial
    begin
        logic [RATE_W-1:0] rate;
        logic [1:0]        kind;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // low tone at 48 kHz: both segment edges and the far end of the index range
        configure(TONE_LOW, RATE_W'(48000));
        send(0);
        send(2879);
        send(2880);
        send(5759);
        send(5760);
        send('1);
        settle();

        // critical tone: first tone, silent gap, second tone, end
        configure(TONE_CRITICAL, RATE_W'(48000));
        send(0);
        send(2879);
        send(2880);
        send(4319);
        send(4320);
        send(8639);
        send(8640);
        settle();

        configure(TONE_NONE, RATE_W'(48000));
        send(100);
        settle();

        configure(TONE_SPARE, RATE_W'(48000));
        send(100);
        settle();

        // zero rate silences everything
        configure(TONE_CRITICAL, '0);
        send(0);
        send(50);
        settle();

        // largest rate, past the nominal maximum
        configure(TONE_CRITICAL, '1);
        send(0);
        send(47184);
        send(47185);
        settle();

        configure(TONE_LOW, RATE_W'(192000));
        send(1);
        send(2);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            gaps_on = (p < PHASES - QUIET_TAIL);
            kind = pick_tone();
            rate = pick_rate();
            configure(kind, rate);
            for (int k = 0; k < PER_PHASE; k++)
                send(pick_index(rate));
            settle();
        end

        $display("Checked %0d samples over %0d tone/rate settings", n_checked, n_settings);
        $display("  %0d positive, %0d negative, %0d silent", n_high, n_down, n_quiet);
        if (n_errors == 0)
        begin
            $display("alert_tone_square_wave_generator verification clean");
        end
        else
        begin
            $display("alert_tone_square_wave_generator verification failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d requests taken of %0d, %0d results outstanding",
                 n_taken, n_sent, sample_q.size());
        $display("alert_tone_square_wave_generator verification failed");
        $finish;
    end

endmodule
